// ----- hw/rtl/horizontal_box_blur_rgb_defines.svh -----
// ----------------------------------------------------------------------------
// Box blur assertion macros
// Shared property forms for the port-level checker of the horizontal box blur.
// ----------------------------------------------------------------------------
`ifndef HORIZONTAL_BOX_BLUR_RGB_DEFINES_SVH
`define HORIZONTAL_BOX_BLUR_RGB_DEFINES_SVH

// consequent in the same cycle
`define HBB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box blur check failed");

// consequent in the next cycle
`define HBB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box blur check failed");

`endif

// ----- hw/rtl/hbb_pkg.sv -----
// ----------------------------------------------------------------------------
// Box blur package
// Sizes, register map, and the command and status words of the blur block.
// ----------------------------------------------------------------------------
package hbb_pkg;

   localparam int MAX_RADIUS = 16;
   localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
   localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
   localparam int CNT_W      = $clog2(WIN_DEPTH + 1);
   localparam int PTR_W      = $clog2(WIN_DEPTH);
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = NUM_CH * CH_W;
   localparam int SUM_W      = $clog2((WIN_DEPTH + 1) * ((1 << CH_W) - 1) + 1);
   localparam int REC_W      = SUM_W + 1;
   localparam int PROD_W     = SUM_W + REC_W;
   localparam int QN_W       = CH_W + CNT_W;

   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 3;
   localparam int CFG_W      = 5;
   localparam logic [CFG_W-1:0]    RADIUS_RESET = CFG_W'(16);
   localparam logic [ADDR_W-3:0]   REG_RADIUS   = '0;

   typedef logic [CH_W-1:0]  chan_type;
   typedef logic [SUM_W-1:0] sum_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic mul;
      logic chk;
      logic load;
      logic trim;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic row_end;
      logic last;
   } status_type;

endpackage

// ----- hw/rtl/hbb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Box blur controller
// Sequences accept, window update, divide, result load and row-end trim.
// ----------------------------------------------------------------------------
module hbb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  hbb_pkg::status_type status,
   output hbb_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_MUL,
      ST_CHK,
      ST_FIN,
      ST_TRIM
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = status.go ? ST_MUL : ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            cmd.chk  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = (status.row_end && !status.last) ? ST_TRIM : ST_IDLE;
            end
         end
         ST_TRIM: begin
            cmd.trim = 1'b1;
            state_in = ST_MUL;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hw/rtl/hbb_dp.sv -----
// ----------------------------------------------------------------------------
// Box blur datapath
// Pixel ring, running channel sums, reciprocal divide and result register.
// ----------------------------------------------------------------------------
module hbb_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  hbb_pkg::cmd_type             cmd,
   output hbb_pkg::status_type          status,
   input  logic [hbb_pkg::CFG_W-1:0]    cfg_radius,
   input  hbb_pkg::chan_type            pix_red,
   input  hbb_pkg::chan_type            pix_green,
   input  hbb_pkg::chan_type            pix_blue,
   input  logic                         pix_row_end,
   output hbb_pkg::chan_type            out_red,
   output hbb_pkg::chan_type            out_green,
   output hbb_pkg::chan_type            out_blue,
   output logic                         out_row_end,
   output logic                         out_run_last
);

   logic [hbb_pkg::PIX_W-1:0]  mem [hbb_pkg::WIN_DEPTH];
   logic [hbb_pkg::PIX_W-1:0]  old_ff;
   logic [hbb_pkg::PIX_W-1:0]  pix_ff;
   logic                       row_end_ff;

   logic [hbb_pkg::PTR_W-1:0]  wr_ff, wr_in, rd_addr;
   logic [hbb_pkg::CNT_W-1:0]  cnt_ff, cnt_in, cnt_upd, rad_plus1, pend;
   logic [hbb_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic [hbb_pkg::RAD_W-1:0]  radius_ff, radius_in, left_ff, left_in, radius_sat;
   logic                       trim_ff, trim_in;
   logic                       win_full, last;
   logic [hbb_pkg::PTR_W:0]    wr_ext, cnt_ext, wrap_addr;

   hbb_pkg::sum_type           sum_ff [hbb_pkg::NUM_CH];
   hbb_pkg::sum_type           sum_in [hbb_pkg::NUM_CH];
   hbb_pkg::sum_type           rem_s  [hbb_pkg::NUM_CH];
   logic [hbb_pkg::PROD_W-1:0] prod_ff [hbb_pkg::NUM_CH];
   logic [hbb_pkg::PROD_W-1:0] prod_in [hbb_pkg::NUM_CH];
   hbb_pkg::chan_type          q0_ff  [hbb_pkg::NUM_CH];
   hbb_pkg::chan_type          q0_in  [hbb_pkg::NUM_CH];
   logic [hbb_pkg::QN_W-1:0]   qn_ff  [hbb_pkg::NUM_CH];
   logic [hbb_pkg::QN_W-1:0]   qn_in  [hbb_pkg::NUM_CH];
   hbb_pkg::chan_type          out_ff [hbb_pkg::NUM_CH];
   hbb_pkg::chan_type          out_in [hbb_pkg::NUM_CH];
   hbb_pkg::chan_type          pix_ch [hbb_pkg::NUM_CH];
   hbb_pkg::chan_type          old_ch [hbb_pkg::NUM_CH];
   logic                       out_row_end_ff, out_last_ff;

   logic [hbb_pkg::REC_W-1:0]  recip_tab [hbb_pkg::WIN_DEPTH + 1];

   assign recip_tab[0] = '0;
   for (genvar g = 1; g <= hbb_pkg::WIN_DEPTH; g++) begin : g_recip
      localparam logic [hbb_pkg::REC_W-1:0] RECIP =
         hbb_pkg::REC_W'((64'd1 << hbb_pkg::SUM_W) / g);
      assign recip_tab[g] = RECIP;
   end

   always_comb begin
      for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
         pix_ch[c] = pix_ff[(hbb_pkg::NUM_CH - 1 - c) * hbb_pkg::CH_W +: hbb_pkg::CH_W];
         old_ch[c] = old_ff[(hbb_pkg::NUM_CH - 1 - c) * hbb_pkg::CH_W +: hbb_pkg::CH_W];
      end
   end

   assign radius_sat = (32'(cfg_radius) > hbb_pkg::MAX_RADIUS) ?
                       hbb_pkg::RAD_W'(hbb_pkg::MAX_RADIUS) : hbb_pkg::RAD_W'(cfg_radius);

   assign win_full  = (cnt_ff == hbb_pkg::CNT_W'({radius_ff, 1'b1}));
   assign cnt_upd   = win_full ? cnt_ff : cnt_ff + 1'b1;
   assign rad_plus1 = hbb_pkg::CNT_W'(radius_ff) + 1'b1;
   assign pend      = (cnt_upd < rad_plus1) ? cnt_upd : rad_plus1;
   assign last      = (rem_ff == hbb_pkg::CNT_W'(1));

   assign status.go      = row_end_ff || (cnt_upd > hbb_pkg::CNT_W'(radius_ff));
   assign status.row_end = row_end_ff;
   assign status.last    = last;

   // oldest pixel held in the sums
   assign wr_ext    = (hbb_pkg::PTR_W + 1)'(wr_ff);
   assign cnt_ext   = (hbb_pkg::PTR_W + 1)'(cnt_ff);
   assign wrap_addr = wr_ext + (hbb_pkg::PTR_W + 1)'(hbb_pkg::WIN_DEPTH) - cnt_ext;
   assign rd_addr   = (wr_ext >= cnt_ext) ? hbb_pkg::PTR_W'(wr_ext - cnt_ext) :
                      wrap_addr[hbb_pkg::PTR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[wr_ff] <= pix_ff;
      end
      old_ff <= mem[rd_addr];
   end

   always_comb begin
      wr_in     = wr_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      radius_in = radius_ff;
      left_in   = left_ff;
      trim_in   = trim_ff;
      for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
         sum_in[c] = sum_ff[c];
      end
      if (cmd.accept && (cnt_ff == '0)) begin
         radius_in = radius_sat;
      end
      if (cmd.update) begin
         wr_in  = (wr_ff == hbb_pkg::PTR_W'(hbb_pkg::WIN_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         cnt_in = cnt_upd;
         rem_in = pend;
         for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
            sum_in[c] = sum_ff[c] + hbb_pkg::SUM_W'(pix_ch[c]) -
                        (win_full ? hbb_pkg::SUM_W'(old_ch[c]) : '0);
         end
      end
      if (cmd.trim && trim_ff) begin
         cnt_in = cnt_ff - 1'b1;
         for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
            sum_in[c] = sum_ff[c] - hbb_pkg::SUM_W'(old_ch[c]);
         end
      end
      if (cmd.load) begin
         left_in = (left_ff == radius_ff) ? left_ff : left_ff + 1'b1;
         trim_in = (left_ff == radius_ff);
         rem_in  = rem_ff - 1'b1;
         if (row_end_ff && last) begin
            cnt_in  = '0;
            left_in = '0;
            for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
               sum_in[c] = '0;
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
         prod_in[c] = hbb_pkg::PROD_W'(sum_ff[c]) * hbb_pkg::PROD_W'(recip_tab[cnt_ff]);
         q0_in[c]   = prod_ff[c][hbb_pkg::SUM_W +: hbb_pkg::CH_W];
         qn_in[c]   = hbb_pkg::QN_W'(q0_in[c]) * hbb_pkg::QN_W'(cnt_ff);
         rem_s[c]   = sum_ff[c] - hbb_pkg::SUM_W'(qn_ff[c]);
         out_in[c]  = (rem_s[c] >= hbb_pkg::SUM_W'(cnt_ff)) ? q0_ff[c] + 1'b1 : q0_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff     <= '0;
         cnt_ff    <= '0;
         rem_ff    <= '0;
         radius_ff <= '0;
         left_ff   <= '0;
         trim_ff   <= 1'b0;
         for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         wr_ff     <= wr_in;
         cnt_ff    <= cnt_in;
         rem_ff    <= rem_in;
         radius_ff <= radius_in;
         left_ff   <= left_in;
         trim_ff   <= trim_in;
         for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff     <= {pix_red, pix_green, pix_blue};
         row_end_ff <= pix_row_end;
      end
      for (int c = 0; c < hbb_pkg::NUM_CH; c++) begin
         if (cmd.mul) begin
            prod_ff[c] <= prod_in[c];
         end
         if (cmd.chk) begin
            q0_ff[c] <= q0_in[c];
            qn_ff[c] <= qn_in[c];
         end
         if (cmd.load) begin
            out_ff[c] <= out_in[c];
         end
      end
      if (cmd.load) begin
         out_row_end_ff <= row_end_ff && last;
         out_last_ff    <= !row_end_ff || last;
      end
   end

   assign out_red      = out_ff[0];
   assign out_green    = out_ff[1];
   assign out_blue     = out_ff[2];
   assign out_row_end  = out_row_end_ff;
   assign out_run_last = out_last_ff;

endmodule

// ----- hw/rtl/horizontal_box_blur_rgb.sv -----
// ----------------------------------------------------------------------------
// Horizontal box blur, RGB
// Averages each pixel with up to blur_radius neighbors on each side in its row,
// per channel, with floor division by the number of pixels inside the row.
// Radius is latched on the first pixel of a row. A pixel that completes no
// result passes through accept and window update only; one that completes a
// result adds reciprocal multiply, remainder check and result load, and the
// load waits while the result register is full. A row end flushes up to the
// latched radius plus one results (17 at most), each further one through
// trim, multiply, check and load again; no pixel is taken during the flush.
// The result register lets the next pixel enter while a result waits.
// ----------------------------------------------------------------------------
module horizontal_box_blur_rgb (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_red_in,
   input  logic [7:0]                   req_green_in,
   input  logic [7:0]                   req_blue_in,
   input  logic                         req_row_end_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_red_out,
   output logic [7:0]                   rsp_green_out,
   output logic [7:0]                   rsp_blue_out,
   output logic                         rsp_row_end_out,
   output logic                         rsp_run_last,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [hbb_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [hbb_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [hbb_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   logic [hbb_pkg::CFG_W-1:0] cfg_radius_ff, cfg_radius_in;
   logic                      csr_sel_radius;
   hbb_pkg::cmd_type          cmd;
   hbb_pkg::status_type       status;

   assign csr_sel_radius = (csr_paddr[hbb_pkg::ADDR_W-1:2] == hbb_pkg::REG_RADIUS);
   assign csr_pready     = 1'b1;
   assign csr_prdata     = csr_sel_radius ? hbb_pkg::DATA_W'(cfg_radius_ff) : '0;

   always_comb begin
      cfg_radius_in = cfg_radius_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_radius) begin
         cfg_radius_in = csr_pwdata[hbb_pkg::CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_radius_ff <= hbb_pkg::RADIUS_RESET;
      end else begin
         cfg_radius_ff <= cfg_radius_in;
      end
   end

   hbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hbb_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg_radius   (cfg_radius_ff),
      .pix_red      (req_red_in),
      .pix_green    (req_green_in),
      .pix_blue     (req_blue_in),
      .pix_row_end  (req_row_end_in),
      .out_red      (rsp_red_out),
      .out_green    (rsp_green_out),
      .out_blue     (rsp_blue_out),
      .out_row_end  (rsp_row_end_out),
      .out_run_last (rsp_run_last)
   );

endmodule

// ----- hw/rtl/hbb_checker.sv -----
// ----------------------------------------------------------------------------
// Box blur port checker
// Port-level properties of the blur block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "horizontal_box_blur_rgb_defines.svh"

module hbb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [7:0]                   rsp_red_out,
   input logic [7:0]                   rsp_green_out,
   input logic [7:0]                   rsp_blue_out,
   input logic                         rsp_row_end_out,
   input logic                         rsp_run_last,
   input logic                         csr_psel,
   input logic                         csr_penable,
   input logic                         csr_pwrite,
   input logic [hbb_pkg::ADDR_W-1:0]   csr_paddr,
   input logic [hbb_pkg::DATA_W-1:0]   csr_pwdata,
   input logic [hbb_pkg::DATA_W-1:0]   csr_prdata,
   input logic                         csr_pready
);

   logic [25:0]               rsp_word;
   logic                      csr_sel;
   logic                      csr_wr_radius;
   logic [hbb_pkg::CFG_W-1:0] rd_radius;
   logic [hbb_pkg::CFG_W-1:0] wr_radius;

   assign rsp_word      = {rsp_red_out, rsp_green_out, rsp_blue_out,
                           rsp_row_end_out, rsp_run_last};
   assign csr_sel       = (csr_paddr[hbb_pkg::ADDR_W-1:2] == hbb_pkg::REG_RADIUS);
   assign csr_wr_radius = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel;
   assign rd_radius     = csr_prdata[hbb_pkg::CFG_W-1:0];
   assign wr_radius     = csr_pwdata[hbb_pkg::CFG_W-1:0];

   `HBB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   `HBB_ASSERT_NEXT(a_one_word, req_valid && req_ready, !req_ready)
   `HBB_ASSERT_SAME(a_flush_blocks, rsp_valid && !rsp_run_last, !req_ready)
   `HBB_ASSERT_NEXT(a_csr_rdback, csr_wr_radius, !csr_sel || rd_radius == $past(wr_radius))

endmodule

bind horizontal_box_blur_rgb hbb_checker u_hbb_checker (.*);

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Horizontal box blur testbench
// Streams rows of RGB pixels through the blur, predicts every blurred word
// from a local copy of the row window and the latched radius, and compares
// each returned word field by field. Directed rows cover the radius extremes,
// single-pixel rows and a radius write in the middle of a row; random rows of
// random length follow, with sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int CNT_SAT      = 2 * hbb_pkg::MAX_RADIUS + 2;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 200;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       last;
   } blur_px_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_red_in = '0;
   logic [7:0]                 req_green_in = '0;
   logic [7:0]                 req_blue_in = '0;
   logic                       req_row_end_in = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [7:0]                 rsp_red_out;
   logic [7:0]                 rsp_green_out;
   logic [7:0]                 rsp_blue_out;
   logic                       rsp_row_end_out;
   logic                       rsp_run_last;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [hbb_pkg::ADDR_W-1:0] csr_paddr = '0;
   logic [hbb_pkg::DATA_W-1:0] csr_pwdata = '0;
   logic [hbb_pkg::DATA_W-1:0] csr_prdata;
   logic                       csr_pready;

   horizontal_box_blur_rgb dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_row_end_in  (req_row_end_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_row_end_out (rsp_row_end_out),
      .rsp_run_last    (rsp_run_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [hbb_pkg::PIX_W-1:0] row_ring [0:hbb_pkg::WIN_DEPTH-1];
   int                        ring_slot = 0;
   int                        row_count = 0;
   int                        blurred_count = 0;
   int                        row_radius = 0;
   int                        radius_reg = 16;
   blur_px_type               blurred_q [$];
   blur_px_type               head_px;

   int err_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;

   int          stall_left = 0;
   int          stall_mode = 0;
   int          stall_bit = 0;
   logic [31:0] stall_word = '1;

   function automatic int imin(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [hbb_pkg::PIX_W-1:0] pixel_back(int back);
      return row_ring[(ring_slot + 2 * hbb_pkg::WIN_DEPTH - 1 - back % hbb_pkg::WIN_DEPTH)
                      % hbb_pkg::WIN_DEPTH];
   endfunction

   function automatic void push_mean(int center, int left, int right,
                                     logic row_end, logic last);
      int                        red_acc = 0;
      int                        green_acc = 0;
      int                        blue_acc = 0;
      int                        count;
      logic [hbb_pkg::PIX_W-1:0] px;
      blur_px_type               mean_px;
      for (int i = center - right; i <= center + left; i++) begin
         px = pixel_back(i);
         red_acc   += px[23:16];
         green_acc += px[15:8];
         blue_acc  += px[7:0];
      end
      count = left + right + 1;
      mean_px.red     = 8'(red_acc / count);
      mean_px.green   = 8'(green_acc / count);
      mean_px.blue    = 8'(blue_acc / count);
      mean_px.row_end = row_end;
      mean_px.last    = last;
      blurred_q.push_back(mean_px);
   endfunction

   function automatic void blur_predict(logic [7:0] red, logic [7:0] green,
                                        logic [7:0] blue, logic row_end);
      int pend;
      int center;
      if (row_count == 0)
         row_radius = imin(radius_reg, hbb_pkg::MAX_RADIUS);
      row_ring[ring_slot] = {red, green, blue};
      ring_slot = (ring_slot + 1) % hbb_pkg::WIN_DEPTH;
      if (row_count < CNT_SAT)
         row_count++;
      if (!row_end) begin
         if (row_count > row_radius) begin
            push_mean(row_radius, imin(blurred_count, row_radius), row_radius, 1'b0, 1'b1);
            if (blurred_count < CNT_SAT)
               blurred_count++;
         end
      end else begin
         pend = imin(row_count, row_radius + 1);
         for (int k = 0; k < pend; k++) begin
            center = pend - 1 - k;
            push_mean(center, imin(blurred_count, row_radius), center,
                      k == pend - 1, k == pend - 1);
            if (blurred_count < CNT_SAT)
               blurred_count++;
         end
         row_count = 0;
         blurred_count = 0;
      end
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (err_count < 100)
         $display("mismatch %s: got %0d want %0d", what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (blurred_q.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            head_px = blurred_q.pop_front();
            if (rsp_red_out !== head_px.red)
               report_mismatch("red", rsp_red_out, head_px.red);
            if (rsp_green_out !== head_px.green)
               report_mismatch("green", rsp_green_out, head_px.green);
            if (rsp_blue_out !== head_px.blue)
               report_mismatch("blue", rsp_blue_out, head_px.blue);
            if (rsp_row_end_out !== head_px.row_end)
               report_mismatch("row_end", rsp_row_end_out, head_px.row_end);
            if (rsp_run_last !== head_px.last)
               report_mismatch("run_last", rsp_run_last, head_px.last);
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(16, 64);
         stall_mode = $urandom_range(0, 3);
         stall_word = $urandom;
      end
      stall_left--;
      stall_bit = (stall_bit + 1) % 32;
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= stall_word[stall_bit];
         end
         2: begin
            rsp_ready <= stall_word[stall_bit] & stall_word[(stall_bit + 7) % 32];
         end
         default: begin
            rsp_ready <= stall_word[stall_bit] | stall_word[(stall_bit + 3) % 32];
         end
      endcase
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic row_end);
      int gap;
      blur_predict(red, green, blue, row_end);
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_red_in     <= red;
      req_green_in   <= green;
      req_blue_in    <= blue;
      req_row_end_in <= row_end;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_radius(input int value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {hbb_pkg::REG_RADIUS, 2'b00};
      csr_pwdata  <= hbb_pkg::DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      radius_reg = value & 31;
   endtask

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_row(input int len);
      for (int i = 0; i < len; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), i == len - 1);
   endtask

   task automatic test_reset_radius();
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      wait_drained();
   endtask

   task automatic test_radius_zero();
      write_radius(0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd1, 8'd2, 8'd3, 1'b1);
      wait_drained();
   endtask

   task automatic test_radius_saturate();
      write_radius(31);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      wait_drained();
   endtask

   task automatic test_radius_change_mid_row();
      write_radius(2);
      send_random_row(0);
      for (int i = 0; i < 4; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      wait_drained();
      write_radius(1);
      send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd127, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
      send_random_row(4);
      wait_drained();
   endtask

   task automatic test_random_rows();
      int sent = 0;
      int len;
      int radius;
      while (sent < RANDOM_WORDS) begin
         if ($urandom_range(0, 3) == 0) begin
            wait_drained();
            case ($urandom_range(0, 5))
               0: radius = 0;
               1: radius = 16;
               2: radius = 31;
               default: radius = $urandom_range(1, 20);
            endcase
            write_radius(radius);
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         case ($urandom_range(0, 11))
            0: len = 1;
            1: len = $urandom_range(35, 45);
            default: len = $urandom_range(2, 2 * imin(radius_reg, hbb_pkg::MAX_RADIUS) + 3);
         endcase
         send_random_row(len);
         sent += len;
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_reset_radius();
      test_radius_zero();
      test_radius_saturate();
      test_radius_change_mid_row();
      test_random_rows();
      wait_drained();
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
